/* rtl/gcp_pkg.sv */
// glyph cache probe: shared types, constants and the start-slot hash
`timescale 1ns / 1ps

package gcp_pkg;

    localparam int NUM_SETS_DEF    = 64;
    localparam int PROBE_DEPTH_DEF = 5;

    localparam int TAG_W   = 48;
    localparam int CNT_W   = 31;
    localparam int SLOT_W  = 7;
    localparam int WIN_W   = 16;
    localparam int HASH_W  = 32;
    localparam int RENORM_SHIFT = 2;

    localparam logic [WIN_W-1:0]  WIN_RESET = 16'd500;
    localparam logic [HASH_W-1:0] HASH_MULT = 32'd17;

    typedef struct packed {
        logic [15:0] font_id;
        logic [15:0] glyph_offset;
        logic [7:0]  glyph_height;
        logic [7:0]  glyph_ascent;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted_recent;
        logic [CNT_W-1:0]  stamp;
    } t_out_item;

    typedef struct packed {
        logic tag_eq;
        logic age_lt;
    } t_cmp_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DECIDE,
        ST_RENORM,
        ST_WRITE
    } t_state;

    // ((id*17 + off)*17 + height + ascent), 32-bit wrapping
    function automatic logic [HASH_W-1:0] f_hash(input t_in_item it);
        logic [HASH_W-1:0] h;
        begin
            h = HASH_W'(it.font_id) * HASH_MULT + HASH_W'(it.glyph_offset);
            h = h * HASH_MULT + HASH_W'(it.glyph_height) + HASH_W'(it.glyph_ascent);
            return h;
        end
    endfunction

endpackage

/* rtl/gcp_cmp.sv */
// glyph cache probe: shared compare unit for tag match and age ordering
`timescale 1ns / 1ps

module gcp_cmp
    import gcp_pkg::*;
(
    input  logic [TAG_W-1:0] i_tag_a,
    input  logic [TAG_W-1:0] i_tag_b,
    input  logic [CNT_W-1:0] i_age_a,
    input  logic [CNT_W-1:0] i_age_b,
    output t_cmp_res         o_res
);

    always_comb begin
        o_res.tag_eq = (i_tag_a == i_tag_b);
        o_res.age_lt = (i_age_a < i_age_b);
    end

endmodule

/* rtl/gcp_table.sv */
// glyph cache probe: tag and age memories with per-entry valid bits
`timescale 1ns / 1ps

module gcp_table
    import gcp_pkg::*;
#(
    parameter int TBL_DEPTH = NUM_SETS_DEF + PROBE_DEPTH_DEF,
    parameter int ADDR_W    = $clog2(NUM_SETS_DEF + PROBE_DEPTH_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [TAG_W-1:0]  o_rd_tag,
    output logic [CNT_W-1:0]  o_rd_age,
    input  logic              i_wr_tag_en,
    input  logic              i_wr_age_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [TAG_W-1:0]  i_wr_tag,
    input  logic [CNT_W-1:0]  i_wr_age
);

    logic [TAG_W-1:0] r_tag_mem [TBL_DEPTH];
    logic [CNT_W-1:0] r_age_mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] r_valid;
    logic [TAG_W-1:0] r_rd_tag;
    logic [CNT_W-1:0] r_rd_age;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_tag_en) begin
            r_tag_mem[i_wr_addr] <= i_wr_tag;
        end
        if (i_wr_age_en) begin
            r_age_mem[i_wr_addr] <= i_wr_age;
        end
        if (i_rd_en) begin
            r_rd_tag <= r_tag_mem[i_rd_addr];
            r_rd_age <= r_age_mem[i_rd_addr];
        end
    end

    // an entry never written reads as tag zero, age zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_tag_en || i_wr_age_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_tag = r_rd_vld ? r_rd_tag : '0;
    assign o_rd_age = r_rd_vld ? r_rd_age : '0;

endmodule

/* rtl/glyph_cache_probe_lru_top.sv */
// glyph cache probe: top level with probe sequencer, age counter and result register
`timescale 1ns / 1ps

// Hashed glyph cache lookup. Each item is hashed to a start slot, then the
// PROBE_DEPTH entries from there are read one per cycle from a tag/age memory
// with one read port and passed through one shared compare unit that looks for a
// tag match and tracks the first entry with the smallest age. A hit refreshes
// the entry's age stamp; a miss overwrites the chosen victim and flags it when
// it was stamped within recent_window of the current count. The probe's pace is
// set by the one-read-per-cycle memory port; the result register lets the next
// lookup probe while a result waits at the output, but its write step holds
// until that result is taken. When the age counter reaches 2^31, that item
// also walks the whole table to shift every age above one right by two.
// The input side stalls while an item is in work.
module glyph_cache_probe_lru_top
    import gcp_pkg::*;
#(
    parameter int NUM_SETS    = NUM_SETS_DEF,
    parameter int PROBE_DEPTH = PROBE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [WIN_W-1:0] i_cfg_wdata
);

    localparam int TBL_DEPTH = NUM_SETS + PROBE_DEPTH;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);
    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int K_W       = $clog2(TBL_DEPTH + 1);

    t_state            r_state, n_state;
    logic [K_W-1:0]    r_k, n_k;
    logic [SET_W-1:0]  r_start;
    logic [TAG_W-1:0]  r_tag;
    logic              r_rd_live;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_hit;
    logic [ADDR_W-1:0] r_hit_idx;
    logic [CNT_W-1:0]  r_min_age;
    logic [ADDR_W-1:0] r_min_idx;
    logic              r_recent;
    logic [CNT_W-1:0]  r_cnt;
    logic [WIN_W-1:0]  r_window;
    logic              r_out_vld;
    t_out_item         r_out_item;

    logic              in_fire;
    logic              wr_fire;
    logic              rd_en;
    logic [K_W-1:0]    rd_sum;
    logic [ADDR_W-1:0] rd_addr;
    logic [TAG_W-1:0]  rd_tag;
    logic [CNT_W-1:0]  rd_age;
    logic              wr_tag_en;
    logic              wr_age_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_age;
    logic [CNT_W-1:0]  cmp_age_a;
    logic [CNT_W-1:0]  cmp_age_b;
    t_cmp_res          cmp_res;
    logic [HASH_W-1:0] hash;
    logic [CNT_W:0]    cnt_inc;
    logic [CNT_W:0]    age_diff;
    logic              renorm;
    logic [CNT_W-1:0]  n_cnt;
    logic              n_recent;
    logic [ADDR_W-1:0] fin_idx;

    assign in_fire = i_in_valid && (r_state == ST_IDLE);
    assign wr_fire = (r_state == ST_WRITE) && (!r_out_vld || !i_out_stall);
    assign hash    = f_hash(i_in_item);
    assign fin_idx = r_hit ? r_hit_idx : r_min_idx;

    // stamp and recent test for the decide step
    assign cnt_inc  = {1'b0, r_cnt} + (CNT_W + 1)'(1);
    assign renorm   = cnt_inc[CNT_W];
    assign n_cnt    = renorm ? CNT_W'(cnt_inc >> RENORM_SHIFT) : cnt_inc[CNT_W-1:0];
    assign age_diff = {1'b0, r_cnt} - {1'b0, r_min_age};
    assign n_recent = !r_hit && (r_min_age != '0)
                      && (age_diff < (CNT_W + 1)'(r_window));

    // sequencer
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        rd_en   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_k = '0;
                if (in_fire) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                rd_en = (r_k < K_W'(PROBE_DEPTH));
                n_k   = r_k + K_W'(1);
                if (r_k == K_W'(PROBE_DEPTH)) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_k     = '0;
                n_state = renorm ? ST_RENORM : ST_WRITE;
            end
            ST_RENORM: begin
                rd_en = (r_k < K_W'(TBL_DEPTH));
                n_k   = r_k + K_W'(1);
                if (r_k == K_W'(TBL_DEPTH)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (wr_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign rd_sum  = (r_state == ST_PROBE) ? (K_W'(r_start) + r_k) : r_k;
    assign rd_addr = rd_sum[ADDR_W-1:0];

    // compare unit: probe orders ages against the running minimum,
    // the renorm walk asks whether an age is above one
    assign cmp_age_a = (r_state == ST_RENORM) ? CNT_W'(1) : rd_age;
    assign cmp_age_b = (r_state == ST_RENORM) ? rd_age : r_min_age;

    gcp_cmp u_cmp (
        .i_tag_a (rd_tag),
        .i_tag_b (r_tag),
        .i_age_a (cmp_age_a),
        .i_age_b (cmp_age_b),
        .o_res   (cmp_res)
    );

    always_comb begin
        wr_tag_en = 1'b0;
        wr_age_en = 1'b0;
        wr_addr   = fin_idx;
        wr_age    = r_cnt;
        if (wr_fire) begin
            wr_tag_en = 1'b1;
            wr_age_en = 1'b1;
        end else if ((r_state == ST_RENORM) && r_rd_live && cmp_res.age_lt) begin
            wr_age_en = 1'b1;
            wr_addr   = r_rd_addr;
            wr_age    = rd_age >> RENORM_SHIFT;
        end
    end

    gcp_table #(
        .TBL_DEPTH (TBL_DEPTH),
        .ADDR_W    (ADDR_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .o_rd_tag    (rd_tag),
        .o_rd_age    (rd_age),
        .i_wr_tag_en (wr_tag_en),
        .i_wr_age_en (wr_age_en),
        .i_wr_addr   (wr_addr),
        .i_wr_tag    (r_tag),
        .i_wr_age    (wr_age)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_k       <= '0;
            r_rd_live <= 1'b0;
            r_cnt     <= '0;
            r_window  <= WIN_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_rd_live <= rd_en;
            if (r_state == ST_DECIDE) begin
                r_cnt <= n_cnt;
            end
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (wr_fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // probe datapath
    always_ff @(posedge i_clk) begin
        r_rd_addr <= rd_addr;
        if (in_fire) begin
            r_start   <= hash[SET_W-1:0];
            r_tag     <= i_in_item;
            r_hit     <= 1'b0;
            r_min_age <= '1;
            r_min_idx <= ADDR_W'(hash[SET_W-1:0]);
        end else if ((r_state == ST_PROBE) && r_rd_live) begin
            // first match wins, first strict minimum wins
            if (cmp_res.tag_eq && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_addr;
            end
            if (cmp_res.age_lt) begin
                r_min_age <= rd_age;
                r_min_idx <= r_rd_addr;
            end
        end
        if (r_state == ST_DECIDE) begin
            r_recent <= n_recent;
        end
        if (wr_fire) begin
            r_out_item.hit            <= r_hit;
            r_out_item.slot           <= SLOT_W'(fin_idx);
            r_out_item.evicted_recent <= r_recent;
            r_out_item.stamp          <= r_cnt;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    a_out_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_WRITE)
        else $error("result appeared outside the write step");

    a_stamp_is_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_fire |=> (o_out_item.stamp == r_cnt) && o_out_valid)
        else $error("result stamp differs from the age counter");

    a_renorm_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE && n_state == ST_RENORM)
        |=> r_cnt == (CNT_W'(1) << (CNT_W - RENORM_SHIFT)))
        else $error("renormalization entered without counter wrap");

    a_hit_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.hit && o_out_item.evicted_recent)
            && (o_out_item.stamp != '0))
        else $error("hit result flagged as eviction or zero stamp");

    a_no_write_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> !wr_tag_en && !wr_age_en)
        else $error("table written during the probe window");

endmodule

/* tb/glyph_cache_probe_lru_top_test.sv */
// testbench for the glyph cache lookup: directed rows, then random items checked against a predictor
`timescale 1ns / 1ps

module glyph_cache_probe_lru_top_test;
    import gcp_pkg::*;

    localparam int          NUM_SETS    = NUM_SETS_DEF;
    localparam int          PROBE_DEPTH = PROBE_DEPTH_DEF;
    localparam int          TABLE_N     = NUM_SETS + PROBE_DEPTH;
    localparam logic [31:0] STEP_MULT   = 32'd17;
    localparam logic [31:0] AGE_WRAP    = 32'h8000_0000;
    localparam int          AGE_SHIFT   = 2;
    localparam int          SETTLE      = 16;
    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          PHASE_ITEMS = 325;
    localparam int          POOL_MAX    = 48;

    typedef enum logic {
        ROW_LOOKUP,
        ROW_WINDOW
    } t_row_kind;

    typedef struct {
        t_row_kind        kind;
        t_in_item         req;
        logic [WIN_W-1:0] window;
        logic             typed;
        t_out_item        want;
    } t_dir_row;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in_item         in_item   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_item;
    logic             cfg_we    = 1'b0;
    logic [WIN_W-1:0] cfg_wdata = '0;

    // typed expectation that travels with the item on the input side
    logic             in_typed  = 1'b0;
    t_out_item        in_want   = '0;

    logic             calm      = 1'b0;
    int unsigned      err_count = 0;
    int unsigned      stall_left = 0;

    // predictor state
    logic [TAG_W-1:0] tag_mem [TABLE_N];
    logic [31:0]      age_mem [TABLE_N];
    logic [31:0]      age_cnt;
    logic [WIN_W-1:0] win_reg;
    t_out_item        pred_res;

    t_out_item        pending_results [$];
    t_in_item         tag_pool [$];
    t_dir_row         dir_rows [$];

    glyph_cache_probe_lru_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic void clear_cache_model();
        for (int i = 0; i < TABLE_N; i++) begin
            tag_mem[i] = '0;
            age_mem[i] = '0;
        end
        age_cnt = '0;
        win_reg = WIN_RESET;
    endfunction

    // advance the age counter, halving twice every stored age above one when it hits 2^31
    function automatic logic [31:0] next_age_stamp();
        age_cnt = age_cnt + 32'd1;
        if (age_cnt >= AGE_WRAP) begin
            for (int i = 0; i < TABLE_N; i++)
                if (age_mem[i] > 32'd1)
                    age_mem[i] = age_mem[i] >> AGE_SHIFT;
            age_cnt = age_cnt >> AGE_SHIFT;
        end
        return age_cnt;
    endfunction

    function automatic t_out_item lookup_glyph(input t_in_item req);
        logic [TAG_W-1:0] tag;
        logic [31:0]      h;
        logic [31:0]      min_age;
        logic [31:0]      st;
        int unsigned      start;
        int unsigned      idx;
        int unsigned      victim;
        int unsigned      k;
        logic             found;
        t_out_item        res;
        tag = req;
        h = (32'(req.font_id) * STEP_MULT + 32'(req.glyph_offset)) * STEP_MULT
            + 32'(req.glyph_height) + 32'(req.glyph_ascent);
        start = h & (NUM_SETS - 1);
        found = 1'b0;
        res = '0;
        for (k = 0; k < PROBE_DEPTH; k++) begin
            idx = start + k;
            if (!found && idx < TABLE_N && tag_mem[idx] == tag) begin
                found = 1'b1;
                st = next_age_stamp();
                age_mem[idx] = st;
                res.hit = 1'b1;
                res.slot = SLOT_W'(idx);
                res.stamp = st[CNT_W-1:0];
            end
        end
        if (!found) begin
            // first entry with the smallest age wins
            victim = start;
            min_age = '1;
            for (k = 0; k < PROBE_DEPTH; k++) begin
                idx = start + k;
                if (idx < TABLE_N && age_mem[idx] < min_age) begin
                    min_age = age_mem[idx];
                    victim = idx;
                end
            end
            if (victim >= TABLE_N)
                victim = 0;
            // recent test uses the count before this access bumps it
            res.evicted_recent = (min_age != 0) && ((age_cnt - min_age) < 32'(win_reg));
            tag_mem[victim] = tag;
            st = next_age_stamp();
            age_mem[victim] = st;
            res.slot = SLOT_W'(victim);
            res.stamp = st[CNT_W-1:0];
        end
        return res;
    endfunction

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            $display("%0t: result with none expected: expected nothing, actual %h", $time, got);
            err_count++;
        end else begin
            want = pending_results.pop_front();
            if (got.hit !== want.hit) begin
                $display("%0t: hit: expected %0d, actual %0d", $time, want.hit, got.hit);
                err_count++;
            end
            if (got.slot !== want.slot) begin
                $display("%0t: slot: expected %0d, actual %0d", $time, want.slot, got.slot);
                err_count++;
            end
            if (got.evicted_recent !== want.evicted_recent) begin
                $display("%0t: evicted_recent: expected %0d, actual %0d", $time,
                         want.evicted_recent, got.evicted_recent);
                err_count++;
            end
            if (got.stamp !== want.stamp) begin
                $display("%0t: stamp: expected %0d, actual %0d", $time, want.stamp, got.stamp);
                err_count++;
            end
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            clear_cache_model();
        end else begin
            if (out_valid && !out_stall)
                check_result(out_item);
            if (in_valid && !in_stall) begin
                // the model advances on every item, typed or not
                pred_res = lookup_glyph(in_item);
                pending_results.push_back(in_typed ? in_want : pred_res);
            end
            if (cfg_we)
                win_reg = cfg_wdata;
        end
    end

    function automatic int unsigned gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // receiver back-pressure
    always @(posedge clk) begin
        if (stall_left != 0)
            stall_left = stall_left - 1;
        else if (!calm && $urandom_range(0, 4) == 0)
            stall_left = gap_len();
        out_stall <= (stall_left != 0);
    end

    task automatic send_lookup(input t_in_item req, input logic typed, input t_out_item want);
        int unsigned gap;
        in_item  <= req;
        in_typed <= typed;
        in_want  <= want;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic void add_lookup(input logic [15:0] id, input logic [15:0] off,
                                       input logic [7:0] ht, input logic [7:0] asc);
        dir_rows.push_back('{ROW_LOOKUP, {id, off, ht, asc}, '0, 1'b0, '0});
    endfunction

    function automatic void add_typed(input logic [15:0] id, input logic [15:0] off,
                                      input logic [7:0] ht, input logic [7:0] asc,
                                      input logic hit, input logic [SLOT_W-1:0] slot,
                                      input logic recent, input logic [CNT_W-1:0] stamp);
        dir_rows.push_back('{ROW_LOOKUP, {id, off, ht, asc}, '0, 1'b1,
                             {hit, slot, recent, stamp}});
    endfunction

    function automatic void add_window(input logic [WIN_W-1:0] value);
        dir_rows.push_back('{ROW_WINDOW, '0, value, 1'b0, '0});
    endfunction

    // mostly reused or clustered tags so windows fill up and evict
    function automatic t_in_item random_lookup();
        t_in_item    req;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45 && tag_pool.size() != 0) begin
            req = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
        end else if (pick < 85) begin
            req.font_id      = 16'($urandom_range(0, 3));
            req.glyph_offset = 16'($urandom_range(0, 31));
            req.glyph_height = 8'($urandom_range(0, 255));
            req.glyph_ascent = 8'($urandom_range(0, 255));
        end else if (pick < 88) begin
            req = '0;
        end else begin
            req = {16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom)};
        end
        tag_pool.push_back(req);
        if (tag_pool.size() > POOL_MAX)
            void'(tag_pool.pop_front());
        return req;
    endfunction

    initial begin
        logic [WIN_W-1:0] phase_windows [6];
        phase_windows = '{16'hFFFF, 16'd0, 16'd1, WIN_RESET,
                          16'($urandom), 16'($urandom_range(0, 2000))};

        // empty entries hold tag zero, so the zero tag hits slot 0
        add_typed(16'h0, 16'h0, 8'h00, 8'h00, 1'b1, 7'd0, 1'b0, 31'd1);
        add_typed(16'h0, 16'h0, 8'h00, 8'h00, 1'b1, 7'd0, 1'b0, 31'd2);
        // fill the window at slot 1; ties go to the lowest index
        add_typed(16'h0, 16'h0, 8'h01, 8'h00, 1'b0, 7'd1, 1'b0, 31'd3);
        add_typed(16'h0, 16'h0, 8'h01, 8'h00, 1'b1, 7'd1, 1'b0, 31'd4);
        add_typed(16'h0, 16'h0, 8'h00, 8'h01, 1'b0, 7'd2, 1'b0, 31'd5);
        add_typed(16'h0, 16'h0, 8'd65, 8'h00, 1'b0, 7'd3, 1'b0, 31'd6);
        add_typed(16'h0, 16'h0, 8'd33, 8'd32, 1'b0, 7'd4, 1'b0, 31'd7);
        add_typed(16'h0, 16'h0, 8'd129, 8'h00, 1'b0, 7'd5, 1'b0, 31'd8);
        // window full: evictions of recently stamped entries
        add_typed(16'h0, 16'h0, 8'd193, 8'h00, 1'b0, 7'd1, 1'b1, 31'd9);
        add_typed(16'h0, 16'h0, 8'h01, 8'h00, 1'b0, 7'd2, 1'b1, 31'd10);
        add_window(16'd0);
        add_typed(16'h0, 16'h0, 8'h00, 8'h01, 1'b0, 7'd3, 1'b0, 31'd11);
        add_window(16'hFFFF);
        add_typed(16'h0, 16'h0, 8'd65, 8'h00, 1'b0, 7'd4, 1'b1, 31'd12);
        add_window(WIN_RESET);
        add_lookup(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        add_lookup(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        add_lookup(16'hFFFF, 16'h0000, 8'h00, 8'h00);
        add_lookup(16'h0000, 16'hFFFF, 8'h00, 8'h00);
        add_lookup(16'h0000, 16'h0000, 8'hFF, 8'h00);
        add_lookup(16'hAAAA, 16'h5555, 8'hAA, 8'h55);
        add_lookup(16'h5555, 16'hAAAA, 8'h55, 8'hAA);
        // last start slot: the window runs past the set count into the extra entries
        add_lookup(16'h0, 16'h0, 8'd63, 8'd0);
        add_lookup(16'h0, 16'h0, 8'd127, 8'd0);
        add_lookup(16'h0, 16'h0, 8'd191, 8'd0);
        add_lookup(16'h0, 16'h0, 8'd255, 8'd0);
        add_lookup(16'h0, 16'h0, 8'd128, 8'd127);
        add_lookup(16'h0, 16'h0, 8'd254, 8'd1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WINDOW)
                write_window(dir_rows[i].window);
            else
                send_lookup(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        end

        foreach (phase_windows[p]) begin
            write_window(phase_windows[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 100 == 0)
                    calm <= ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 149) == 0)
                    wait_drained();
                send_lookup(random_lookup(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (err_count == 0)
            $display("glyph_cache_probe_lru_top: match");
        else
            $display("glyph_cache_probe_lru_top: mismatch");
        $finish;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("glyph_cache_probe_lru_top: mismatch");
        $finish;
    end

endmodule

/* glyph_cache_probe_lru_top.f */
rtl/gcp_pkg.sv
rtl/gcp_cmp.sv
rtl/gcp_table.sv
rtl/glyph_cache_probe_lru_top.sv
tb/glyph_cache_probe_lru_top_test.sv
